@@ rtl/core/assert_macros.svh @@
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define POLAR2X2_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// fixed-delay implication, skipped while reset is high
`define POLAR2X2_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("delayed check failed");

`endif

@@ rtl/core/polar2x2_pkg.sv @@
package polar2x2_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int ONE_Q      = 1 << FRAC_BITS;
   localparam int ROT_W      = 14;

   // magnitudes entering the normalization are below 2^RED_W
   localparam int RED_W      = 17;
   localparam int SQR_W      = 2 * RED_W;
   localparam int DEN_W      = SQR_W + 1;
   localparam int PART_W     = DEN_W + 1;

   // quotient is a^2 / n scaled by 2^SCALE_BITS, so its root is 2 * ONE_Q at most
   localparam int SCALE_BITS = 2 * (FRAC_BITS + 1);
   localparam int QUO_W      = SCALE_BITS + 1;
   localparam int RAD_W      = QUO_W + 1;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SREM_W     = ROOT_W + 2;

   localparam int DIV_CELLS  = QUO_W;
   localparam int SQRT_CELLS = ROOT_W;

   typedef struct packed {
      logic [PART_W-1:0] part;
      logic [QUO_W-1:0]  quo;
   } div_lane_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_lane_type;

endpackage

@@ rtl/core/polar_decomposition_2x2.sv @@
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// request   | start / busy          | req_f00 req_f01 req_f10 req_f11
// result    | rsp_valid (strobe)    | rsp_rot_cos rsp_rot_sin rsp_sym00..rsp_sym11
//           |                       | rsp_degenerate
//
// one matrix is taken on every clock edge with start high; busy stays low
// each result beat is strobed on rsp_valid and taken while the strobe is high
// each result passes through the 27-cell restoring divider row and the 14-cell root row,
// plus seven registers for input, magnitude, squares, sum, sign, products and output
// reset clears only the valid pipeline; the receiver cannot stall the result strobe
`include "assert_macros.svh"

module polar_decomposition_2x2 import polar2x2_pkg::*; #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_f00,
   input  logic signed [DATA_WIDTH-1:0] req_f01,
   input  logic signed [DATA_WIDTH-1:0] req_f10,
   input  logic signed [DATA_WIDTH-1:0] req_f11,
   output logic                         rsp_valid,
   output logic signed [ROT_W-1:0]      rsp_rot_cos,
   output logic signed [ROT_W-1:0]      rsp_rot_sin,
   output logic signed [DATA_WIDTH-1:0] rsp_sym00,
   output logic signed [DATA_WIDTH-1:0] rsp_sym01,
   output logic signed [DATA_WIDTH-1:0] rsp_sym10,
   output logic signed [DATA_WIDTH-1:0] rsp_sym11,
   output logic                         rsp_degenerate
);

   localparam int MAG_W    = DATA_WIDTH + 1;
   localparam int EXT_W    = (MAG_W > RED_W) ? MAG_W : RED_W;
   localparam int SH_W     = $clog2(EXT_W);
   localparam int LINE_LEN = 3 + DIV_CELLS + SQRT_CELLS;
   localparam int LATENCY  = LINE_LEN + 4;
   localparam int PROD_W   = ROT_W + DATA_WIDTH;
   localparam int SUM_W    = PROD_W + 2;
   localparam int HALF_LSB = ONE_Q / 2;

   localparam int IDX_00 = 0;
   localparam int IDX_01 = 1;
   localparam int IDX_10 = 2;
   localparam int IDX_11 = 3;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic degen;
   } flag_type;

   // request register
   logic                         accept;
   logic                         req_vld_ff;
   logic signed [DATA_WIDTH-1:0] req_mat_ff [0:3];

   // magnitude stage
   logic [MAG_W-1:0]  x_val, y_val, ax_val, ay_val;
   logic [EXT_W-1:0]  ax_ext, ay_ext, mag_or, ax_sh, ay_sh;
   logic [SH_W-1:0]   sh_amt;
   flag_type          flag_in;
   logic [RED_W-1:0]  red_a_ff, red_b_ff;

   // squares and divisor
   logic [SQR_W-1:0]  sq_a_ff, sq_b_ff, num_a_ff, num_b_ff;
   logic [DEN_W-1:0]  den_ff;

   // side line that runs beside the cell rows
   logic [LINE_LEN-1:0]          vld_ff;
   flag_type                     flag_ff [0:LINE_LEN-1];
   logic signed [DATA_WIDTH-1:0] mat_ff  [0:LINE_LEN-1][0:3];

   // cell rows
   logic [DEN_W-1:0] den_w    [0:DIV_CELLS];
   div_lane_type     div_c_w  [0:DIV_CELLS];
   div_lane_type     div_s_w  [0:DIV_CELLS];
   sqrt_lane_type    sqrt_c_w [0:SQRT_CELLS];
   sqrt_lane_type    sqrt_s_w [0:SQRT_CELLS];

   // sign stage
   logic [ROOT_W:0]              root_c_inc, root_s_inc;
   logic [ROT_W-1:0]             mag_c, mag_s;
   logic signed [ROT_W-1:0]      cos_in, sin_in;
   logic signed [ROT_W-1:0]      rot_c_ff, rot_s_ff;
   logic signed [DATA_WIDTH-1:0] dmat_ff [0:3];
   logic                         d_degen_ff, d_vld_ff;

   // product stage
   logic signed [PROD_W-1:0] pc00_ff, ps10_ff, pc01_ff, ps11_ff;
   logic signed [PROD_W-1:0] pc10_ff, ps00_ff, pc11_ff, ps01_ff;
   logic signed [ROT_W-1:0]  e_cos_ff, e_sin_ff;
   logic                     e_degen_ff, e_vld_ff;

   // output stage
   logic signed [SUM_W-1:0]      sum00, sum01, sum10, sum11;
   logic                         out_vld_ff;
   logic signed [ROT_W-1:0]      out_cos_ff, out_sin_ff;
   logic signed [DATA_WIDTH-1:0] out_s00_ff, out_s01_ff, out_s10_ff, out_s11_ff;
   logic                         out_degen_ff;

   function automatic logic signed [DATA_WIDTH-1:0] round_sat(
      input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] rnd;
      logic signed [SUM_W-1:0] lim;
      rnd = (sum + SUM_W'(HALF_LSB)) >>> FRAC_BITS;
      if (rnd > SAT_HI) begin
         lim = SAT_HI;
      end else if (rnd < SAT_LO) begin
         lim = SAT_LO;
      end else begin
         lim = rnd;
      end
      return lim[DATA_WIDTH-1:0];
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         vld_ff     <= '0;
         d_vld_ff   <= 1'b0;
         e_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= accept;
         vld_ff     <= {vld_ff[LINE_LEN-2:0], req_vld_ff};
         d_vld_ff   <= vld_ff[LINE_LEN-1];
         e_vld_ff   <= d_vld_ff;
         out_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_mat_ff[IDX_00] <= req_f00;
      req_mat_ff[IDX_01] <= req_f01;
      req_mat_ff[IDX_10] <= req_f10;
      req_mat_ff[IDX_11] <= req_f11;
   end

   // x, y, their magnitudes, and the halving that keeps them below 2^RED_W
   always_comb begin
      x_val = {req_mat_ff[IDX_00][DATA_WIDTH-1], req_mat_ff[IDX_00]}
            + {req_mat_ff[IDX_11][DATA_WIDTH-1], req_mat_ff[IDX_11]};
      y_val = {req_mat_ff[IDX_10][DATA_WIDTH-1], req_mat_ff[IDX_10]}
            - {req_mat_ff[IDX_01][DATA_WIDTH-1], req_mat_ff[IDX_01]};
      ax_val = x_val[MAG_W-1] ? (~x_val + 1'b1) : x_val;
      ay_val = y_val[MAG_W-1] ? (~y_val + 1'b1) : y_val;
      ax_ext = EXT_W'(ax_val);
      ay_ext = EXT_W'(ay_val);
      mag_or = ax_ext | ay_ext;
      sh_amt = '0;
      for (int k = 1; k <= EXT_W - RED_W; k++) begin
         if (|(mag_or >> (RED_W - 1 + k))) begin
            sh_amt = SH_W'(k);
         end
      end
      ax_sh = ax_ext >> sh_amt;
      ay_sh = ay_ext >> sh_amt;
      flag_in.x_neg = x_val[MAG_W-1];
      flag_in.y_neg = y_val[MAG_W-1];
      flag_in.degen = (x_val == '0) && (y_val == '0);
   end

   always_ff @(posedge clock) begin
      red_a_ff <= ax_sh[RED_W-1:0];
      red_b_ff <= ay_sh[RED_W-1:0];
      sq_a_ff  <= SQR_W'(red_a_ff) * SQR_W'(red_a_ff);
      sq_b_ff  <= SQR_W'(red_b_ff) * SQR_W'(red_b_ff);
      num_a_ff <= sq_a_ff;
      num_b_ff <= sq_b_ff;
      den_ff   <= DEN_W'(sq_a_ff) + DEN_W'(sq_b_ff);
   end

   always_ff @(posedge clock) begin
      flag_ff[0] <= flag_in;
      mat_ff[0]  <= req_mat_ff;
      for (int i = 1; i < LINE_LEN; i++) begin
         flag_ff[i] <= flag_ff[i-1];
         mat_ff[i]  <= mat_ff[i-1];
      end
   end

   // divider row: quotient = a^2 * 2^SCALE_BITS / n, one bit a cell
   assign den_w[0]   = den_ff;
   assign div_c_w[0] = {PART_W'(num_a_ff), {QUO_W{1'b0}}};
   assign div_s_w[0] = {PART_W'(num_b_ff), {QUO_W{1'b0}}};

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      polar2x2_div_cell u_div (
         .clock  (clock),
         .up_den (den_w[g]),
         .up_c   (div_c_w[g]),
         .up_s   (div_s_w[g]),
         .dn_den (den_w[g+1]),
         .dn_c   (div_c_w[g+1]),
         .dn_s   (div_s_w[g+1])
      );
   end

   // root row: twice the scaled cosine and sine
   assign sqrt_c_w[0] = {1'b0, div_c_w[DIV_CELLS].quo, {SREM_W{1'b0}}, {ROOT_W{1'b0}}};
   assign sqrt_s_w[0] = {1'b0, div_s_w[DIV_CELLS].quo, {SREM_W{1'b0}}, {ROOT_W{1'b0}}};

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      polar2x2_sqrt_cell u_sqrt (
         .clock (clock),
         .up_c  (sqrt_c_w[g]),
         .up_s  (sqrt_s_w[g]),
         .dn_c  (sqrt_c_w[g+1]),
         .dn_s  (sqrt_s_w[g+1])
      );
   end

   // halve with rounding, apply signs, identity for a zero rotation vector
   always_comb begin
      root_c_inc = {1'b0, sqrt_c_w[SQRT_CELLS].root} + 1'b1;
      root_s_inc = {1'b0, sqrt_s_w[SQRT_CELLS].root} + 1'b1;
      mag_c = root_c_inc[ROOT_W:1];
      mag_s = root_s_inc[ROOT_W:1];
      if (flag_ff[LINE_LEN-1].degen) begin
         cos_in = ROT_W'(ONE_Q);
         sin_in = '0;
      end else begin
         cos_in = flag_ff[LINE_LEN-1].x_neg ? -mag_c : mag_c;
         sin_in = flag_ff[LINE_LEN-1].y_neg ? -mag_s : mag_s;
      end
   end

   always_ff @(posedge clock) begin
      rot_c_ff   <= cos_in;
      rot_s_ff   <= sin_in;
      dmat_ff    <= mat_ff[LINE_LEN-1];
      d_degen_ff <= flag_ff[LINE_LEN-1].degen;
   end

   always_ff @(posedge clock) begin
      pc00_ff    <= PROD_W'(rot_c_ff) * PROD_W'(dmat_ff[IDX_00]);
      ps10_ff    <= PROD_W'(rot_s_ff) * PROD_W'(dmat_ff[IDX_10]);
      pc01_ff    <= PROD_W'(rot_c_ff) * PROD_W'(dmat_ff[IDX_01]);
      ps11_ff    <= PROD_W'(rot_s_ff) * PROD_W'(dmat_ff[IDX_11]);
      pc10_ff    <= PROD_W'(rot_c_ff) * PROD_W'(dmat_ff[IDX_10]);
      ps00_ff    <= PROD_W'(rot_s_ff) * PROD_W'(dmat_ff[IDX_00]);
      pc11_ff    <= PROD_W'(rot_c_ff) * PROD_W'(dmat_ff[IDX_11]);
      ps01_ff    <= PROD_W'(rot_s_ff) * PROD_W'(dmat_ff[IDX_01]);
      e_cos_ff   <= rot_c_ff;
      e_sin_ff   <= rot_s_ff;
      e_degen_ff <= d_degen_ff;
   end

   // s = r^t f
   always_comb begin
      sum00 = SUM_W'(pc00_ff) + SUM_W'(ps10_ff);
      sum01 = SUM_W'(pc01_ff) + SUM_W'(ps11_ff);
      sum10 = SUM_W'(pc10_ff) - SUM_W'(ps00_ff);
      sum11 = SUM_W'(pc11_ff) - SUM_W'(ps01_ff);
   end

   always_ff @(posedge clock) begin
      out_cos_ff   <= e_cos_ff;
      out_sin_ff   <= e_sin_ff;
      out_s00_ff   <= round_sat(sum00);
      out_s01_ff   <= round_sat(sum01);
      out_s10_ff   <= round_sat(sum10);
      out_s11_ff   <= round_sat(sum11);
      out_degen_ff <= e_degen_ff;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_rot_cos    = out_cos_ff;
   assign rsp_rot_sin    = out_sin_ff;
   assign rsp_sym00      = out_s00_ff;
   assign rsp_sym01      = out_s01_ff;
   assign rsp_sym10      = out_s10_ff;
   assign rsp_sym11      = out_s11_ff;
   assign rsp_degenerate = out_degen_ff;

   `POLAR2X2_IMPLY(a_cos_range, clock, reset, rsp_valid, (rsp_rot_cos <= ONE_Q) && (rsp_rot_cos >= -ONE_Q))
   `POLAR2X2_IMPLY(a_sin_range, clock, reset, rsp_valid, (rsp_rot_sin <= ONE_Q) && (rsp_rot_sin >= -ONE_Q))
   `POLAR2X2_IMPLY(a_degen_ident, clock, reset, rsp_valid && rsp_degenerate, (rsp_rot_cos == ONE_Q) && (rsp_rot_sin == 0))
   `POLAR2X2_DELAY(a_latency, clock, reset, start && !busy, LATENCY, rsp_valid)
   `POLAR2X2_IMPLY(a_no_orphan, clock, reset, rsp_valid, $past(start, LATENCY))

endmodule

@@ rtl/core/polar2x2_div_cell.sv @@
module polar2x2_div_cell import polar2x2_pkg::*; (
   input  logic              clock,
   input  logic [DEN_W-1:0]  up_den,
   input  div_lane_type      up_c,
   input  div_lane_type      up_s,
   output logic [DEN_W-1:0]  dn_den,
   output div_lane_type      dn_c,
   output div_lane_type      dn_s
);

   logic [DEN_W-1:0] den_ff;
   div_lane_type     c_lane_ff, c_lane_in;
   div_lane_type     s_lane_ff, s_lane_in;

   // one restoring quotient bit; partial remainder leaves already doubled
   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [DEN_W-1:0] den);
      logic [PART_W-1:0] diff;
      logic              take;
      div_lane_type      res;
      take     = lane.part >= {1'b0, den};
      diff     = lane.part - {1'b0, den};
      res.part = take ? {diff[DEN_W-1:0], 1'b0} : {lane.part[DEN_W-1:0], 1'b0};
      res.quo  = {lane.quo[QUO_W-2:0], take};
      return res;
   endfunction

   always_comb begin
      c_lane_in = div_step(up_c, up_den);
      s_lane_in = div_step(up_s, up_den);
   end

   always_ff @(posedge clock) begin
      den_ff    <= up_den;
      c_lane_ff <= c_lane_in;
      s_lane_ff <= s_lane_in;
   end

   assign dn_den = den_ff;
   assign dn_c   = c_lane_ff;
   assign dn_s   = s_lane_ff;

endmodule

@@ rtl/core/polar2x2_sqrt_cell.sv @@
module polar2x2_sqrt_cell import polar2x2_pkg::*; (
   input  logic          clock,
   input  sqrt_lane_type up_c,
   input  sqrt_lane_type up_s,
   output sqrt_lane_type dn_c,
   output sqrt_lane_type dn_s
);

   sqrt_lane_type c_lane_ff, c_lane_in;
   sqrt_lane_type s_lane_ff, s_lane_in;

   // one root bit from the top two radicand bits
   function automatic sqrt_lane_type sqrt_step(input sqrt_lane_type lane);
      logic [SREM_W+1:0] cur;
      logic [SREM_W+1:0] trial;
      logic              take;
      sqrt_lane_type     res;
      cur      = {lane.rem, lane.rad[RAD_W-1 -: 2]};
      trial    = {2'b00, lane.root, 2'b01};
      take     = cur >= trial;
      res.rem  = take ? SREM_W'(cur - trial) : cur[SREM_W-1:0];
      res.root = {lane.root[ROOT_W-2:0], take};
      res.rad  = {lane.rad[RAD_W-3:0], 2'b00};
      return res;
   endfunction

   always_comb begin
      c_lane_in = sqrt_step(up_c);
      s_lane_in = sqrt_step(up_s);
   end

   always_ff @(posedge clock) begin
      c_lane_ff <= c_lane_in;
      s_lane_ff <= s_lane_in;
   end

   assign dn_c = c_lane_ff;
   assign dn_s = s_lane_ff;

endmodule
